// ===== rtl/core/pet_pkg.sv =====
// Shared types and constants for the periodic event timer.
package pet_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned ACC_W   = TIME_W + 1;
	localparam int unsigned STEP_W  = $clog2(ACC_W);
	localparam int unsigned ADDR_W  = 4;
	localparam int unsigned DATA_W  = 32;

	typedef enum logic [1:0] {
		ACT_ADVANCE = 2'd0,
		ACT_START   = 2'd1,
		ACT_PRELOAD = 2'd2,
		ACT_STOP    = 2'd3
	} action_t;

	// register index = paddr[3:2]
	typedef enum logic [1:0] {
		REG_PERIOD  = 2'd0,
		REG_LIMIT   = 2'd1,
		REG_START   = 2'd2,
		REG_NONE    = 2'd3
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_PUSH
	} state_t;

	typedef struct packed {
		logic              start;
		logic [ACC_W-1:0]  dividend;
		logic [TIME_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [TIME_W-1:0] rem;
	} div_rsp_t;

endpackage

// ===== rtl/core/pet_div.sv =====
// Iterative restoring remainder unit, one dividend bit per cycle.
module pet_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pet_pkg::div_req_t req,
	output pet_pkg::div_rsp_t rsp
);

	logic                        busy_q;
	logic                        done_q;
	logic [pet_pkg::STEP_W-1:0]  step_q;
	logic [pet_pkg::ACC_W-1:0]   num_q;
	logic [pet_pkg::TIME_W-1:0]  den_q;
	logic [pet_pkg::TIME_W-1:0]  rem_q;

	logic [pet_pkg::ACC_W-1:0]   trial;
	logic                        fits;
	logic [pet_pkg::ACC_W-1:0]   diff;

	// partial remainder stays below the divisor, so the shifted value fits ACC_W bits
	assign trial = {rem_q, num_q[pet_pkg::ACC_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= pet_pkg::STEP_W'(pet_pkg::ACC_W - 1);
			end else if (busy_q) begin
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.dividend;
			den_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[pet_pkg::ACC_W-2:0], 1'b0};
			rem_q <= fits ? diff[pet_pkg::TIME_W-1:0] : trial[pet_pkg::TIME_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== rtl/core/periodic_event_timer.sv =====
// Top level of the periodic event timer: config registers, sequencer, result register.
//
// Usage notes
// - Input channel (in_valid/in_stall): one transfer carries action, elapsed and
//   preload. in_stall is high whenever an item is in progress; the next transfer
//   is taken only once the previous result has been placed in the output register.
// - Output channel (out_valid/out_stall): exactly one transfer per input item,
//   carrying fired, running and accumulated (state after the item).
// - Sequence: a captured start, stop, preload or non-expiring advance is worked on
//   in the exec state, then pushed to the output register once the slot is free.
//   An expiring advance with nonzero period first runs the remainder unit, one
//   accumulator bit per cycle over 33 bits, before the push. The block takes
//   the next input item only after that push, with the block back in idle.
// - Receiver stall: the result holds in the output register; the block still
//   takes and works on one more item, which then waits until the slot frees.
// - Config: APB writes at 0x0 period, 0x4 repeat_limit, 0x8 start_running;
//   writing it loads the run flag too. Users must make writes while idle; unchecked.
// - Reset: config and timer registers zero, timer stopped, no result pending.
module periodic_event_timer (
	input  logic                         clk,
	input  logic                         arst_n,
	// input channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [1:0]                   action,
	input  logic [pet_pkg::TIME_W-1:0]   elapsed,
	input  logic [pet_pkg::TIME_W-1:0]   preload,
	// output channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         fired,
	output logic                         running,
	output logic [pet_pkg::TIME_W-1:0]   accumulated,
	// APB config port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [pet_pkg::ADDR_W-1:0]   paddr,
	input  logic [pet_pkg::DATA_W-1:0]   pwdata,
	output logic [pet_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);

	// config registers
	logic [pet_pkg::TIME_W-1:0]  period_q;
	logic [pet_pkg::COUNT_W-1:0] limit_q;
	logic                        start_run_q;

	// timer state
	logic                        run_q;
	logic [pet_pkg::TIME_W-1:0]  acc_q;
	logic [pet_pkg::COUNT_W-1:0] cnt_q;

	// captured input transfer
	pet_pkg::action_t            act_q;
	logic [pet_pkg::TIME_W-1:0]  elapsed_q;
	logic [pet_pkg::TIME_W-1:0]  preload_q;
	logic                        fire_q;

	// output register
	logic                        out_valid_q;
	logic                        out_fired_q;
	logic                        out_run_q;
	logic [pet_pkg::TIME_W-1:0]  out_acc_q;

	pet_pkg::state_t             state_q, state_d;
	pet_pkg::div_req_t           div_req;
	pet_pkg::div_rsp_t           div_rsp;

	logic                        cfg_wr;
	pet_pkg::reg_idx_t           cfg_idx;
	logic [pet_pkg::ACC_W-1:0]   sum;
	logic                        accept;
	logic                        slot_free;

	// next-state values from the sequencer
	logic                        upd;
	logic                        run_d;
	logic [pet_pkg::TIME_W-1:0]  acc_d;
	logic [pet_pkg::COUNT_W-1:0] cnt_d;
	logic                        fire_d;
	logic                        do_count;
	logic [pet_pkg::COUNT_W-1:0] cnt_inc;
	logic                        push;

	// ---------------- APB ----------------
	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = pet_pkg::reg_idx_t'(paddr[3:2]);

	always_comb begin
		unique case (cfg_idx)
			pet_pkg::REG_PERIOD: prdata = period_q;
			pet_pkg::REG_LIMIT:  prdata = pet_pkg::DATA_W'(limit_q);
			pet_pkg::REG_START:  prdata = pet_pkg::DATA_W'(start_run_q);
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= '0;
			limit_q     <= '0;
			start_run_q <= 1'b0;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				pet_pkg::REG_PERIOD: period_q    <= pwdata[pet_pkg::TIME_W-1:0];
				pet_pkg::REG_LIMIT:  limit_q     <= pwdata[pet_pkg::COUNT_W-1:0];
				pet_pkg::REG_START:  start_run_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// ---------------- sequencer ----------------
	assign accept    = in_valid & ~in_stall;
	assign slot_free = ~out_valid_q | ~out_stall;
	assign sum       = {1'b0, acc_q} + {1'b0, elapsed_q};

	// saturating fire count; limit of zero never stops the timer
	assign cnt_inc = (cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;

	always_comb begin
		state_d          = state_q;
		in_stall         = 1'b1;
		div_req.start    = 1'b0;
		div_req.dividend = sum;
		div_req.divisor  = period_q;
		upd              = 1'b0;
		run_d            = run_q;
		acc_d            = acc_q;
		cnt_d            = cnt_q;
		fire_d           = 1'b0;
		do_count         = 1'b0;
		push             = 1'b0;

		unique case (state_q)
			pet_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = pet_pkg::ST_EXEC;
				end
			end
			pet_pkg::ST_EXEC: begin
				state_d = pet_pkg::ST_PUSH;
				upd     = 1'b1;
				unique case (act_q)
					pet_pkg::ACT_ADVANCE: begin
						if (run_q) begin
							if (period_q == '0) begin
								acc_d    = '0;
								fire_d   = 1'b1;
								do_count = 1'b1;
							end else if (sum >= {1'b0, period_q}) begin
								// expired: remainder comes from the divider
								upd           = 1'b0;
								div_req.start = 1'b1;
								state_d       = pet_pkg::ST_DIV;
							end else begin
								acc_d = sum[pet_pkg::TIME_W-1:0];
							end
						end
					end
					pet_pkg::ACT_START: begin
						run_d = 1'b1;
						cnt_d = '0;
					end
					pet_pkg::ACT_PRELOAD: begin
						run_d = 1'b1;
						cnt_d = '0;
						acc_d = preload_q;
					end
					pet_pkg::ACT_STOP: begin
						run_d = 1'b0;
					end
					default: ;
				endcase
			end
			pet_pkg::ST_DIV: begin
				if (div_rsp.done) begin
					upd      = 1'b1;
					acc_d    = div_rsp.rem;
					fire_d   = 1'b1;
					do_count = 1'b1;
					state_d  = pet_pkg::ST_PUSH;
				end
			end
			pet_pkg::ST_PUSH: begin
				if (slot_free) begin
					push    = 1'b1;
					state_d = pet_pkg::ST_IDLE;
				end
			end
			default: state_d = pet_pkg::ST_IDLE;
		endcase

		if (do_count && limit_q != '0) begin
			cnt_d = cnt_inc;
			if (cnt_inc >= limit_q) begin
				run_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pet_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// timer state; a start_running write reloads the run flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			acc_q  <= '0;
			cnt_q  <= '0;
			fire_q <= 1'b0;
		end else begin
			if (upd) begin
				run_q  <= run_d;
				acc_q  <= acc_d;
				cnt_q  <= cnt_d;
				fire_q <= fire_d;
			end
			if (cfg_wr && cfg_idx == pet_pkg::REG_START) begin
				run_q <= pwdata[0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q     <= pet_pkg::action_t'(action);
			elapsed_q <= elapsed;
			preload_q <= preload;
		end
	end

	// ---------------- remainder unit ----------------
	pet_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (~out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_fired_q <= fire_q;
			out_run_q   <= run_q;
			out_acc_q   <= acc_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign fired       = out_fired_q;
	assign running     = out_run_q;
	assign accumulated = out_acc_q;

endmodule

// ===== bench/periodic_event_timer_tb.sv =====
// Self-checking testbench for the periodic event timer.
module periodic_event_timer_tb;
	import pet_pkg::*;

	// Quiet cycles (no transfer on either channel) before the run is declared hung.
	// Worst legal gap: receiver hold-off plus a full remainder pass plus a register write.
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int HOLD_CYCLES     = 300;
	localparam int RAND_PHASES     = 8;
	localparam int ITEMS_PER_PHASE = 125;
	localparam int DRAIN_CYCLES    = 40;
	localparam int PRINT_LIMIT     = 40;

	typedef struct packed {
		logic              fired;
		logic              running;
		logic [TIME_W-1:0] acc;
	} timer_out_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	// One directed step: either an item or a register write (idx, value in a).
	// Items with typed set carry their expected result; the rest go to the predictor.
	typedef struct packed {
		row_kind_t   kind;
		action_t     act;
		reg_idx_t    idx;
		logic [31:0] a;
		logic [31:0] b;
		logic        typed;
		timer_out_t  want;
	} plan_row_t;

	localparam int PLAN_ROWS = 33;
	localparam plan_row_t PLAN [PLAN_ROWS] = '{
		// stopped after reset: advance does nothing
		'{ROW_ITEM, ACT_ADVANCE, REG_NONE, 32'hFFFF_FFFF, 32'h0, 1'b1, '{1'b0, 1'b0, 32'd0}},
		'{ROW_ITEM, ACT_STOP,    REG_NONE, 32'h0, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b0, 32'd0}},
		'{ROW_ITEM, ACT_START,   REG_NONE, 32'h0, 32'h0, 1'b1, '{1'b0, 1'b1, 32'd0}},
		// period zero fires on every advance, whatever the elapsed time
		'{ROW_ITEM, ACT_ADVANCE, REG_NONE, 32'd5, 32'h0, 1'b1, '{1'b1, 1'b1, 32'd0}},
		'{ROW_ITEM, ACT_ADVANCE, REG_NONE, 32'd0, 32'h0, 1'b1, '{1'b1, 1'b1, 32'd0}},
		'{ROW_CFG,  ACT_ADVANCE, REG_PERIOD, 32'd100, 32'h0, 1'b0, '0},
		'{ROW_ITEM, ACT_ADVANCE, REG_NONE, 32'd40, 32'h0, 1'b1, '{1'b0, 1'b1, 32'd40}},
		'{ROW_ITEM, ACT_ADVANCE, REG_NONE, 32'd60, 32'h0, 1'b1, '{1'b1, 1'b1, 32'd0}},
		// preload above the period: next advance fires and keeps the remainder
		'{ROW_ITEM, ACT_PRELOAD, REG_NONE, 32'h0, 32'd250, 1'b1, '{1'b0, 1'b1, 32'd250}},
		'{ROW_ITEM, ACT_ADVANCE, REG_NONE, 32'd0, 32'h0, 1'b1, '{1'b1, 1'b1, 32'd50}},
		// repeat limit of two: second fire stops the timer
		'{ROW_CFG,  ACT_ADVANCE, REG_LIMIT, 32'd2, 32'h0, 1'b0, '0},
		'{ROW_ITEM, ACT_START,   REG_NONE, 32'h0, 32'h0, 1'b1, '{1'b0, 1'b1, 32'd50}},
		'{ROW_ITEM, ACT_ADVANCE, REG_NONE, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
		'{ROW_ITEM, ACT_ADVANCE, REG_NONE, 32'd99, 32'h0, 1'b0, '0},
		'{ROW_ITEM, ACT_ADVANCE, REG_NONE, 32'd1, 32'h0, 1'b0, '0},
		// limit lowered below the fire count
		'{ROW_CFG,  ACT_ADVANCE, REG_LIMIT, 32'd5, 32'h0, 1'b0, '0},
		'{ROW_CFG,  ACT_ADVANCE, REG_PERIOD, 32'd1, 32'h0, 1'b0, '0},
		'{ROW_ITEM, ACT_START,   REG_NONE, 32'h0, 32'h0, 1'b0, '0},
		'{ROW_ITEM, ACT_ADVANCE, REG_NONE, 32'd1, 32'h0, 1'b0, '0},
		'{ROW_ITEM, ACT_ADVANCE, REG_NONE, 32'd1, 32'h0, 1'b0, '0},
		'{ROW_ITEM, ACT_ADVANCE, REG_NONE, 32'd1, 32'h0, 1'b0, '0},
		'{ROW_CFG,  ACT_ADVANCE, REG_LIMIT, 32'd2, 32'h0, 1'b0, '0},
		'{ROW_ITEM, ACT_ADVANCE, REG_NONE, 32'd7, 32'h0, 1'b0, '0},
		// widest period and preload, accumulator carries into bit 32
		'{ROW_CFG,  ACT_ADVANCE, REG_PERIOD, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
		'{ROW_CFG,  ACT_ADVANCE, REG_LIMIT, 32'd0, 32'h0, 1'b0, '0},
		'{ROW_ITEM, ACT_PRELOAD, REG_NONE, 32'h0, 32'hFFFF_FFFF, 1'b1, '{1'b0, 1'b1, 32'hFFFF_FFFF}},
		'{ROW_ITEM, ACT_ADVANCE, REG_NONE, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
		// write to the unused slot must change nothing
		'{ROW_CFG,  ACT_ADVANCE, REG_NONE, 32'hFFFF_FFFF, 32'h0, 1'b0, '0},
		// start_running write also loads the run flag
		'{ROW_CFG,  ACT_ADVANCE, REG_START, 32'd0, 32'h0, 1'b0, '0},
		'{ROW_ITEM, ACT_ADVANCE, REG_NONE, 32'd3, 32'h0, 1'b0, '0},
		'{ROW_CFG,  ACT_ADVANCE, REG_START, 32'd1, 32'h0, 1'b0, '0},
		'{ROW_ITEM, ACT_ADVANCE, REG_NONE, 32'hFFFF_FFFE, 32'h0, 1'b0, '0},
		'{ROW_ITEM, ACT_STOP,    REG_NONE, 32'h0, 32'h0, 1'b0, '0}
	};

	// Clock, reset and block ports; every input has a known value from time zero.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] action = ACT_ADVANCE;
	logic [TIME_W-1:0] elapsed = '0;
	logic [TIME_W-1:0] preload = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic fired;
	logic running;
	logic [TIME_W-1:0] accumulated;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	// Predictor state: registers and timer, mirrored at the block's widths.
	logic [TIME_W-1:0]  cfg_period = '0;
	logic [COUNT_W-1:0] cfg_limit = '0;
	logic               cfg_start = 1'b0;
	logic               run_flag = 1'b0;
	logic [ACC_W-1:0]   acc_m = '0;
	logic [COUNT_W-1:0] fire_cnt = '0;

	timer_out_t pending_results[$];

	int mismatches = 0;
	int items_sent = 0;
	int results_seen = 0;
	int fires_seen = 0;
	int reg_writes = 0;
	int quiet_cycles = 0;
	bit gaps_on = 1'b1;      // random idle bursts on both channels
	int hold_asked = 0;      // bumped by the sender to request a long receiver hold-off
	int hold_seen = 0;
	int hold_left = 0;
	int stall_left = 0;

	periodic_event_timer uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.elapsed     (elapsed),
		.preload     (preload),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.fired       (fired),
		.running     (running),
		.accumulated (accumulated),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report_mismatch(string msg);
		if (mismatches < PRINT_LIMIT)
			$display("ERROR result %0d: %s", results_seen, msg);
		mismatches++;
	endtask

	// Timer behavior for one transfer: updates the mirrored state, returns the result.
	function automatic timer_out_t timer_next(action_t act, logic [TIME_W-1:0] el,
			logic [TIME_W-1:0] pre);
		timer_out_t r;
		r.fired = 1'b0;
		case (act)
		ACT_ADVANCE: begin
			if (run_flag) begin
				if (cfg_period == '0) begin
					acc_m = '0;
					r.fired = 1'b1;
				end else begin
					acc_m = acc_m + {1'b0, el};
					if (acc_m >= {1'b0, cfg_period}) begin
						acc_m = acc_m % {1'b0, cfg_period};
						r.fired = 1'b1;
					end
				end
			end
		end
		ACT_START: begin
			run_flag = 1'b1;
			fire_cnt = '0;
		end
		ACT_PRELOAD: begin
			acc_m = {1'b0, pre};
			run_flag = 1'b1;
			fire_cnt = '0;
		end
		default: run_flag = 1'b0;
		endcase
		// fire count saturates instead of wrapping
		if (r.fired && cfg_limit != '0) begin
			if (fire_cnt != '1)
				fire_cnt = fire_cnt + 1'b1;
			if (fire_cnt >= cfg_limit)
				run_flag = 1'b0;
		end
		r.running = run_flag;
		r.acc = acc_m[TIME_W-1:0];
		return r;
	endfunction

	// Offer one item and hold it until the block takes it. Called on a rising edge;
	// valid stays high on return so the next item can follow at once.
	task automatic send_item(action_t act, logic [TIME_W-1:0] el, logic [TIME_W-1:0] pre,
			logic typed, timer_out_t want);
		timer_out_t pred;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		elapsed <= el;
		preload <= pre;
		do @(posedge clk); while (in_stall);
		pred = timer_next(act, el, pre);
		pending_results.push_back(typed ? want : pred);
		items_sent++;
	endtask

	// Sender pauses until every outstanding result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// APB write: setup cycle, then access until pready, then the bus returns to idle.
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		REG_PERIOD: cfg_period = value[TIME_W-1:0];
		REG_LIMIT:  cfg_limit = value[COUNT_W-1:0];
		REG_START: begin
			cfg_start = value[0];
			run_flag = value[0];
		end
		default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	// Result side: compare each transfer with the oldest prediction, then
	// choose the next stall. A requested hold-off outranks the random bursts.
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				if (fired !== pending_results[0].fired)
					report_mismatch($sformatf("fired %b, expected %b",
						fired, pending_results[0].fired));
				if (running !== pending_results[0].running)
					report_mismatch($sformatf("running %b, expected %b",
						running, pending_results[0].running));
				if (accumulated !== pending_results[0].acc)
					report_mismatch($sformatf("accumulated %h, expected %h",
						accumulated, pending_results[0].acc));
				if (pending_results[0].fired)
					fires_seen++;
				void'(pending_results.pop_front());
			end
			results_seen++;
		end
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else if (hold_seen != hold_asked) begin
			hold_seen <= hold_asked;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 10);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Hang detector: any transfer on either channel resets the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, pending_results.size());
			$display("periodic_event_timer: mismatch");
			$finish;
		end
	end

	initial begin
		action_t r_act;
		logic [TIME_W-1:0] r_el;
		logic [TIME_W-1:0] r_pre;
		logic [DATA_W-1:0] r_val;
		int unsigned pick;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (PLAN[i].kind == ROW_CFG) begin
				wait_drained();
				write_reg(PLAN[i].idx, PLAN[i].a);
			end else begin
				send_item(PLAN[i].act, PLAN[i].a, PLAN[i].b, PLAN[i].typed, PLAN[i].want);
			end
		end

		// Random phases, each with its own register setting. First two pin the period
		// extremes; the last, and every third from phase 2, run without idling.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			wait_drained();
			gaps_on = (ph != RAND_PHASES - 1) && (ph % 3 != 2);
			case ($urandom_range(0, 4))
			0: r_val = '0;
			1: r_val = $urandom_range(1, 16);
			2: r_val = $urandom_range(17, 1000);
			3: r_val = $urandom;
			default: r_val = '1;
			endcase
			if (ph == 0)
				r_val = '0;
			else if (ph == 1)
				r_val = '1;
			write_reg(REG_PERIOD, r_val);
			case ($urandom_range(0, 3))
			0: r_val = '0;
			1: r_val = $urandom_range(1, 4);
			2: r_val = $urandom_range(5, 65535);
			default: r_val = 32'hFFFF;
			endcase
			if (ph == 1)
				r_val = 32'hFFFF;
			write_reg(REG_LIMIT, r_val);
			write_reg(REG_START, $urandom_range(0, 1));

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// long receiver hold-off while items keep coming: block backs up
				if (ph == 3 && n == 10)
					hold_asked++;
				pick = $urandom_range(0, 99);
				if (pick < 62)
					r_act = ACT_ADVANCE;
				else if (pick < 75)
					r_act = ACT_START;
				else if (pick < 88)
					r_act = ACT_PRELOAD;
				else
					r_act = ACT_STOP;
				case ($urandom_range(0, 5))
				0: r_el = '0;
				1: r_el = '1;
				2: r_el = $urandom;
				3: r_el = $urandom_range(0, 31);
				// land one below, on, or one past the period boundary
				default: r_el = cfg_period - acc_m[TIME_W-1:0] + $urandom_range(0, 2) - 1;
				endcase
				case ($urandom_range(0, 4))
				0: r_pre = $urandom;
				1: r_pre = '1;
				2: r_pre = '0;
				3: r_pre = $urandom_range(0, cfg_period);
				default: r_pre = cfg_period + $urandom_range(0, 3);
				endcase
				send_item(r_act, r_el, r_pre, 1'b0, '0);
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run covered %0d items, %0d results (%0d fires), %0d register writes,",
			items_sent, results_seen, fires_seen, reg_writes);
		$display("including repeat limits, period extremes and a %0d-cycle receiver hold-off",
			HOLD_CYCLES);
		if (mismatches == 0)
			$display("periodic_event_timer: match");
		else
			$display("periodic_event_timer: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/pet_pkg.sv
rtl/core/pet_div.sv
rtl/core/periodic_event_timer.sv
bench/periodic_event_timer_tb.sv
